// ----- hdl/box_against_plane_set_test_assert.svh -----
// assertion macros shared by the checker of the box against plane set test
// expects signals named clock and reset in the module that uses them
`ifndef BOX_AGAINST_PLANE_SET_TEST_ASSERT_SVH
`define BOX_AGAINST_PLANE_SET_TEST_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define BAPS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define BAPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/baps_pkg.sv -----
// package of the box against plane set test: request codes, verdicts, states
// and the command and status structs between controller and datapath
`timescale 1ns / 1ps

package baps_pkg;

   localparam int NORMAL_W = 16;
   localparam int LIMIT_W  = 48;
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int CORNER_W = 33;
   localparam int PROD_W   = 49;
   localparam int DOT_W    = 51;

   typedef enum logic [1:0] {
      REQ_SET     = 2'd0,
      REQ_DISABLE = 2'd1,
      REQ_TEST    = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      VERDICT_OUTSIDE   = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_INSIDE    = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEAR,
      ST_FAR,
      ST_DRAIN,
      ST_RESULT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request payload and write plane store
      logic start_pass; // reset plane counter and exceed flag
      logic far_pass;   // farthest-corner pass, else nearest
      logic step;       // issue the current plane into the pipeline
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_plane; // current plane is the final one
      logic idle_pipe;  // no plane in flight
      logic exceeded;   // a plane of this pass was exceeded
   } dp_stat_type;

endpackage

// ----- hdl/baps_datapath.sv -----
// datapath of the box against plane set test: plane store, corner, product
// and compare pipeline, depends on baps_pkg
`timescale 1ns / 1ps

module baps_datapath
   import baps_pkg::*;
#(
   parameter int PLANE_COUNT = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   input  logic [1:0]                 req_kind,
   input  logic [3:0]                 plane_index,
   input  logic signed [COORD_W-1:0]  vec_x,
   input  logic signed [COORD_W-1:0]  vec_y,
   input  logic signed [COORD_W-1:0]  vec_z,
   input  logic signed [LIMIT_W-1:0]  plane_offset,
   input  logic [2:0]                 octant,
   input  logic [RADIUS_W-1:0]        radius_x,
   input  logic [RADIUS_W-1:0]        radius_y,
   input  logic [RADIUS_W-1:0]        radius_z
);

   localparam int IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int CNT_W = $clog2(PLANE_COUNT + 1);

   // plane store
   logic signed [NORMAL_W-1:0] nx_ff [PLANE_COUNT];
   logic signed [NORMAL_W-1:0] ny_ff [PLANE_COUNT];
   logic signed [NORMAL_W-1:0] nz_ff [PLANE_COUNT];
   logic signed [LIMIT_W-1:0]  lim_ff [PLANE_COUNT];
   logic [2:0]                 sgn_ff [PLANE_COUNT];
   logic [PLANE_COUNT-1:0]     en_ff;

   // captured box
   logic signed [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [RADIUS_W-1:0]       rx_ff, ry_ff, rz_ff;
   logic [3:0]                skip_ff;

   // pass control
   logic [CNT_W-1:0] cnt_ff;
   logic             exc_ff;

   // pipeline stage 1: corners, stage 2: products, stage 3: sum and compare
   logic                        v1_ff, v2_ff;
   logic signed [CORNER_W-1:0]  k1_ff [3];
   logic signed [NORMAL_W-1:0]  n1_ff [3];
   logic signed [LIMIT_W-1:0]   l1_ff, l2_ff;
   logic signed [PROD_W-1:0]    p2_ff [3];

   logic [IDX_W-1:0] cur;
   logic             cur_live;
   logic signed [LIMIT_W-1:0] neg_d;
   logic signed [DOT_W-1:0]   dot;
   logic signed [CORNER_W-1:0] cc [3];
   logic signed [CORNER_W-1:0] rr [3];

   // current plane counts unless disabled or skipped
   assign cur = cnt_ff[IDX_W-1:0];
   assign cur_live = en_ff[cur] && (skip_ff != 4'(cnt_ff));
   assign neg_d = (plane_offset == {1'b1, {(LIMIT_W-1){1'b0}}}) ?
                  {1'b0, {(LIMIT_W-1){1'b1}}} : -plane_offset;

   always_comb begin
      cc[0] = {cx_ff[COORD_W-1], cx_ff};
      cc[1] = {cy_ff[COORD_W-1], cy_ff};
      cc[2] = {cz_ff[COORD_W-1], cz_ff};
      rr[0] = {2'b00, rx_ff};
      rr[1] = {2'b00, ry_ff};
      rr[2] = {2'b00, rz_ff};
   end

   // plane store writes
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0;
         for (int i = 0; i < PLANE_COUNT; i++) begin
            nx_ff[i] <= '0; ny_ff[i] <= '0; nz_ff[i] <= '0;
            lim_ff[i] <= '0; sgn_ff[i] <= 3'b111;
         end
      end else if (cmd.load) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            if (req_kind == REQ_CLEAR ||
                (req_kind == REQ_DISABLE && plane_index == 4'(i))) begin
               en_ff[i] <= 1'b0;
               nx_ff[i] <= '0; ny_ff[i] <= '0; nz_ff[i] <= '0;
               lim_ff[i] <= '0; sgn_ff[i] <= 3'b111;
            end else if (req_kind == REQ_SET && plane_index == 4'(i)) begin
               en_ff[i] <= 1'b1;
               nx_ff[i] <= vec_x[NORMAL_W-1:0];
               ny_ff[i] <= vec_y[NORMAL_W-1:0];
               nz_ff[i] <= vec_z[NORMAL_W-1:0];
               lim_ff[i] <= neg_d;
               sgn_ff[i] <= octant;
            end
         end
      end
   end

   // box capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff <= vec_x; cy_ff <= vec_y; cz_ff <= vec_z;
         rx_ff <= radius_x; ry_ff <= radius_y; rz_ff <= radius_z;
         skip_ff <= plane_index;
      end
   end

   // plane counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start_pass) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // corner stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.step && cur_live;
      end
      for (int a = 0; a < 3; a++) begin
         k1_ff[a] <= (sgn_ff[cur][a] == cmd.far_pass) ? cc[a] + rr[a] : cc[a] - rr[a];
      end
      n1_ff[0] <= nx_ff[cur];
      n1_ff[1] <= ny_ff[cur];
      n1_ff[2] <= nz_ff[cur];
      l1_ff <= lim_ff[cur];
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      for (int a = 0; a < 3; a++) begin
         p2_ff[a] <= PROD_W'(n1_ff[a] * k1_ff[a]);
      end
      l2_ff <= l1_ff;
   end

   // sum and compare
   assign dot = DOT_W'(p2_ff[0]) + DOT_W'(p2_ff[1]) + DOT_W'(p2_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         exc_ff <= 1'b0;
      end else if (cmd.start_pass) begin
         exc_ff <= 1'b0;
      end else if (v2_ff && dot > DOT_W'(l2_ff)) begin
         exc_ff <= 1'b1;
      end
   end

   assign stat.last_plane = (cnt_ff == CNT_W'(PLANE_COUNT - 1));
   assign stat.idle_pipe  = !v1_ff && !v2_ff;
   assign stat.exceeded   = exc_ff;

endmodule

// ----- hdl/baps_controller.sv -----
// controller of the box against plane set test: sequences the two passes
// and holds the result register, depends on baps_pkg
`timescale 1ns / 1ps

module baps_controller
   import baps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  logic [1:0]  req_kind,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  verdict,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   ctrl_state_type state_ff, state_in;
   logic           far_ff, far_in;
   logic [1:0]     verdict_ff, verdict_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         far_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         far_ff   <= far_in;
      end
      verdict_ff <= verdict_in;
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      far_in     = far_ff;
      verdict_in = verdict_ff;
      cmd        = '0;
      cmd.far_pass = far_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               if (req_kind == REQ_TEST) begin
                  cmd.start_pass = 1'b1;
                  far_in   = 1'b0;
                  state_in = ST_NEAR;
               end
            end
         end
         ST_NEAR, ST_FAR: begin
            cmd.step = 1'b1;
            if (stat.last_plane) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (stat.idle_pipe) begin
               if (!far_ff && stat.exceeded) begin
                  verdict_in = VERDICT_OUTSIDE;
                  state_in   = ST_RESULT;
               end else if (!far_ff) begin
                  cmd.start_pass = 1'b1;
                  far_in   = 1'b1;
                  state_in = ST_FAR;
               end else begin
                  verdict_in = stat.exceeded ? VERDICT_INTERSECT : VERDICT_INSIDE;
                  state_in   = ST_RESULT;
               end
            end
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign verdict = verdict_ff;

endmodule

// ----- hdl/box_against_plane_set_test.sv -----
// top level of the box against plane set test: controller plus datapath
// depends on baps_pkg, baps_controller and baps_datapath
`timescale 1ns / 1ps

// Culls axis-aligned boxes against up to PLANE_COUNT stored planes. Set,
// disable and clear requests give no result. A test request steps one
// plane per cycle through a three-stage corner, multiply and compare
// pipeline, first for the nearest corner and, if no plane is exceeded,
// again for the farthest. The result is held until it is taken. One
// request is handled at a time.
module box_against_plane_set_test
   import baps_pkg::*;
#(
   parameter int PLANE_COUNT = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: plane_index[3:0], vec_x[35:4], vec_y[67:36], vec_z[99:68],
   // plane_offset[147:100], octant[150:148], radius_x[181:151],
   // radius_y[212:182], radius_z[243:213], zero fill to 248
   input  logic [247:0] req_tdata,
   // tuser: req_type
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: verdict[1:0], zero fill
   output logic [7:0]   rsp_tdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [1:0]  verdict;

   baps_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_tvalid && req_tready),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .verdict   (verdict),
      .cmd       (cmd),
      .stat      (stat)
   );

   baps_datapath #(.PLANE_COUNT(PLANE_COUNT)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_kind     (req_tuser),
      .plane_index  (req_tdata[3:0]),
      .vec_x        (req_tdata[35:4]),
      .vec_y        (req_tdata[67:36]),
      .vec_z        (req_tdata[99:68]),
      .plane_offset (req_tdata[147:100]),
      .octant       (req_tdata[150:148]),
      .radius_x     (req_tdata[181:151]),
      .radius_y     (req_tdata[212:182]),
      .radius_z     (req_tdata[243:213])
   );

   assign rsp_tdata = {6'b0, verdict};

endmodule

// ----- hdl/baps_checker.sv -----
// port checker of the box against plane set test and its bind
// depends on baps_pkg and box_against_plane_set_test_assert.svh
`timescale 1ns / 1ps
`include "box_against_plane_set_test_assert.svh"

module baps_checker
   import baps_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata
);

   logic test_fire;
   logic other_fire;
   logic rsp_stall;

   // accepted requests split by kind
   assign test_fire  = req_tvalid && req_tready && (req_tuser == REQ_TEST);
   assign other_fire = req_tvalid && req_tready && (req_tuser != REQ_TEST);
   assign rsp_stall  = rsp_tvalid && !rsp_tready;

   // verdict is never the unused code
   `BAPS_ASSERT_IMPL(a_verdict_code, rsp_tvalid, rsp_tdata[1:0] <= VERDICT_INSIDE, "bad verdict")
   // no result while a new request can be taken
   `BAPS_ASSERT_IMPL(a_one_at_a_time, rsp_tvalid, !req_tready, "overlap")
   // a result never follows a non-test request directly
   `BAPS_ASSERT_NEXT(a_no_spurious, other_fire, !rsp_tvalid, "spurious result")
   // a test request blocks input in the next cycle
   `BAPS_ASSERT_NEXT(a_test_busy, test_fire, !req_tready, "test not busy")
   // a stalled result holds
   `BAPS_ASSERT_NEXT(a_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result dropped")

endmodule

bind box_against_plane_set_test baps_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
